// ===== rtl/sqe_pkg.sv =====
// ----------------------------------------------------------------------------
// sqe_pkg
// Shared types, widths and vertex ordering for the segment to quad extruder.
// ----------------------------------------------------------------------------
package sqe_pkg;

  localparam int COORD_W = 32;
  localparam int DIFF_W  = 33;
  localparam int NORM_W  = 31;
  localparam int THICK_W = 31;
  localparam int COLOR_W = 16;
  localparam int PROD_W  = 62;
  localparam int SQ_W    = 63;
  localparam int ROOT_W  = 32;
  localparam int DEN_W   = 33;
  localparam int NUM_W   = 63;
  localparam int MAG_W   = 31;
  localparam int N_W     = 33;
  localparam int IDX_W   = 3;

  localparam logic [IDX_W-1:0] VTX_FIRST = 3'd0;
  localparam logic [IDX_W-1:0] VTX_LAST  = 3'd5;

  typedef struct packed {
    logic signed [COORD_W-1:0] p1_x;
    logic signed [COORD_W-1:0] p1_y;
    logic signed [COORD_W-1:0] p1_z;
    logic signed [COORD_W-1:0] p2_x;
    logic signed [COORD_W-1:0] p2_y;
    logic signed [COORD_W-1:0] p2_z;
    logic [COLOR_W-1:0]        red;
    logic [COLOR_W-1:0]        green;
    logic [COLOR_W-1:0]        blue;
    logic                      nonzero;
    logic                      dy_pos;
    logic                      dx_neg;
  } seg_t;

  typedef struct packed {
    seg_t              seg;
    logic [PROD_W-1:0] num_x;
    logic [PROD_W-1:0] num_y;
  } side_t;

  // Vertices 2, 3 and 5 sit on the second endpoint.
  function automatic logic vtx_use_p2(input logic [IDX_W-1:0] k);
    return k inside {3'd2, 3'd3, 3'd5};
  endfunction

  // Vertices 1, 4 and 5 take the negated normal.
  function automatic logic vtx_neg(input logic [IDX_W-1:0] k);
    return k inside {3'd1, 3'd4, 3'd5};
  endfunction

  function automatic logic signed [COORD_W-1:0] sat32(input logic signed [33:0] v);
    logic signed [COORD_W-1:0] r;
    if (v[33:31] == 3'b000 || v[33:31] == 3'b111) begin
      r = v[31:0];
    end else if (v[33]) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'sh7FFF_FFFF;
    end
    return r;
  endfunction

endpackage

// ===== rtl/segment_to_quad_extruder.sv =====
// ----------------------------------------------------------------------------
// segment_to_quad_extruder
// Turns a 3D line segment into a thick quad of two triangles, six vertices.
//
//   Channel  Handshake              Payload
//   in       in_valid / in_stall    p1_*, p2_*, thickness, color_*
//   out      out_valid / out_stall  vert_*, out_*, vertex_index, last_vertex
//   cfg      cfg_we                 cfg_wdata (with_color)
//
// An item passes 72 register stages to its first vertex: six front stages,
// 32 square root stages, 32 divider stages, the vertex holding register and
// the output register. One vertex leaves per cycle while out_stall is low;
// the serializer takes the next item as the last vertex of the current one
// loads. Reset clears all valid bits and sets with_color to 1. While an item
// waits at the busy serializer's input, the whole pipeline holds.
// ----------------------------------------------------------------------------
module segment_to_quad_extruder (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic                                cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [sqe_pkg::COORD_W-1:0]  p1_x,
  input  logic signed [sqe_pkg::COORD_W-1:0]  p1_y,
  input  logic signed [sqe_pkg::COORD_W-1:0]  p1_z,
  input  logic signed [sqe_pkg::COORD_W-1:0]  p2_x,
  input  logic signed [sqe_pkg::COORD_W-1:0]  p2_y,
  input  logic signed [sqe_pkg::COORD_W-1:0]  p2_z,
  input  logic [sqe_pkg::THICK_W-1:0]         thickness,
  input  logic [sqe_pkg::COLOR_W-1:0]         color_red,
  input  logic [sqe_pkg::COLOR_W-1:0]         color_green,
  input  logic [sqe_pkg::COLOR_W-1:0]         color_blue,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [sqe_pkg::COORD_W-1:0]  vert_x,
  output logic signed [sqe_pkg::COORD_W-1:0]  vert_y,
  output logic signed [sqe_pkg::COORD_W-1:0]  vert_z,
  output logic [sqe_pkg::COLOR_W-1:0]         out_red,
  output logic [sqe_pkg::COLOR_W-1:0]         out_green,
  output logic [sqe_pkg::COLOR_W-1:0]         out_blue,
  output logic [sqe_pkg::IDX_W-1:0]           vertex_index,
  output logic                                last_vertex
);
  import sqe_pkg::*;

  logic              with_color;
  logic              adv;
  logic              take;
  logic              sum_valid;
  logic [SQ_W-1:0]   sum_sq;
  side_t             sum_side;
  logic              root_valid;
  logic [ROOT_W-1:0] root;
  side_t             root_side;
  logic              tail_valid;
  seg_t              tail_seg;
  logic [MAG_W-1:0]  mag_x, mag_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      with_color <= 1'b1;
    end else if (cfg_we) begin
      with_color <= cfg_wdata;
    end
  end

  assign in_stall = !adv;
  assign take     = in_valid && adv;

  sqe_front u_front (
    .clk, .rst, .adv, .take, .with_color,
    .p1_x, .p1_y, .p1_z, .p2_x, .p2_y, .p2_z,
    .thickness, .color_red, .color_green, .color_blue,
    .sum_valid, .sum_sq, .sum_side
  );

  sqe_root u_root (
    .clk, .rst, .adv,
    .in_valid  (sum_valid),
    .in_sq     (sum_sq),
    .in_side   (sum_side),
    .out_valid (root_valid),
    .out_root  (root),
    .out_side  (root_side)
  );

  sqe_div u_div (
    .clk, .rst, .adv,
    .in_valid  (root_valid),
    .in_root   (root),
    .in_side   (root_side),
    .out_valid (tail_valid),
    .out_seg   (tail_seg),
    .mag_x, .mag_y
  );

  sqe_emit u_emit (
    .clk, .rst, .tail_valid, .tail_seg, .mag_x, .mag_y, .adv,
    .out_stall, .out_valid, .vert_x, .vert_y, .vert_z,
    .out_red, .out_green, .out_blue, .vertex_index, .last_vertex
  );

  a_idle_no_stall: assert property (@(posedge clk) disable iff (rst)
    !tail_valid |-> !in_stall)
    else $error("input stalled with an empty pipeline tail");

  a_last_index: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_vertex |-> vertex_index == VTX_LAST)
    else $error("last_vertex on a vertex other than the sixth");

  a_index_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> vertex_index <= VTX_LAST)
    else $error("vertex_index out of range");

  a_next_vertex: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && vertex_index != VTX_LAST
    |=> out_valid && vertex_index == $past(vertex_index) + 3'd1)
    else $error("vertex sequence broken within an item");

endmodule

// ===== rtl/sqe_front.sv =====
// ----------------------------------------------------------------------------
// sqe_front
// Differences, magnitudes, normalization, products and the sum of squares.
// ----------------------------------------------------------------------------
module sqe_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                adv,
  input  logic                                take,
  input  logic                                with_color,
  input  logic signed [sqe_pkg::COORD_W-1:0]  p1_x,
  input  logic signed [sqe_pkg::COORD_W-1:0]  p1_y,
  input  logic signed [sqe_pkg::COORD_W-1:0]  p1_z,
  input  logic signed [sqe_pkg::COORD_W-1:0]  p2_x,
  input  logic signed [sqe_pkg::COORD_W-1:0]  p2_y,
  input  logic signed [sqe_pkg::COORD_W-1:0]  p2_z,
  input  logic [sqe_pkg::THICK_W-1:0]         thickness,
  input  logic [sqe_pkg::COLOR_W-1:0]         color_red,
  input  logic [sqe_pkg::COLOR_W-1:0]         color_green,
  input  logic [sqe_pkg::COLOR_W-1:0]         color_blue,
  output logic                                sum_valid,
  output logic [sqe_pkg::SQ_W-1:0]            sum_sq,
  output sqe_pkg::side_t                      sum_side
);
  import sqe_pkg::*;

  logic                       v1, v2, v3, v4, v5;
  seg_t                       seg1, seg2, seg3, seg4, seg5;
  logic [THICK_W-1:0]         th1, th2, th3, th4;
  logic signed [DIFF_W-1:0]   dx1, dy1;
  logic [NORM_W-1:0]          ax2, ay2, ax3, ay3, ax4, ay4;
  logic [PROD_W-1:0]          sqx5, sqy5, numx5, numy5;
  logic [DIFF_W-1:0]          adx, ady;
  logic [NORM_W-1:0]          ax_r, ay_r;
  logic [NORM_W-1:0]          a_hi, b_hi, o_hi;
  logic [NORM_W-1:0]          a_lo, b_lo, o_lo;
  seg_t                       seg_in;

  always_comb begin
    seg_in.p1_x    = p1_x;
    seg_in.p1_y    = p1_y;
    seg_in.p1_z    = p1_z;
    seg_in.p2_x    = p2_x;
    seg_in.p2_y    = p2_y;
    seg_in.p2_z    = p2_z;
    seg_in.red     = with_color ? color_red   : '0;
    seg_in.green   = with_color ? color_green : '0;
    seg_in.blue    = with_color ? color_blue  : '0;
    seg_in.nonzero = (p1_x != p2_x) || (p1_y != p2_y);
    seg_in.dy_pos  = p2_y > p1_y;
    seg_in.dx_neg  = p2_x < p1_x;
  end

  always_comb begin
    adx = dx1[DIFF_W-1] ? DIFF_W'(-dx1) : DIFF_W'(dx1);
    ady = dy1[DIFF_W-1] ? DIFF_W'(-dy1) : DIFF_W'(dy1);
    if (adx[31] | ady[31]) begin
      ax_r = adx[31:1];
      ay_r = ady[31:1];
    end else begin
      ax_r = adx[30:0];
      ay_r = ady[30:0];
    end
  end

  always_comb begin
    a_hi = ax2;
    b_hi = ay2;
    o_hi = a_hi | b_hi;
    if (o_hi[30:15] == 16'd0) begin
      a_hi = a_hi << 16;
      b_hi = b_hi << 16;
    end
    o_hi = a_hi | b_hi;
    if (o_hi[30:23] == 8'd0) begin
      a_hi = a_hi << 8;
      b_hi = b_hi << 8;
    end
  end

  always_comb begin
    a_lo = ax3;
    b_lo = ay3;
    o_lo = a_lo | b_lo;
    if (o_lo[30:27] == 4'd0) begin
      a_lo = a_lo << 4;
      b_lo = b_lo << 4;
    end
    o_lo = a_lo | b_lo;
    if (o_lo[30:29] == 2'd0) begin
      a_lo = a_lo << 2;
      b_lo = b_lo << 2;
    end
    o_lo = a_lo | b_lo;
    if (!o_lo[30]) begin
      a_lo = a_lo << 1;
      b_lo = b_lo << 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      v5        <= 1'b0;
      sum_valid <= 1'b0;
    end else if (adv) begin
      v1        <= take;
      v2        <= v1;
      v3        <= v2;
      v4        <= v3;
      v5        <= v4;
      sum_valid <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      seg1  <= seg_in;
      th1   <= thickness;
      dx1   <= DIFF_W'(p2_x) - DIFF_W'(p1_x);
      dy1   <= DIFF_W'(p2_y) - DIFF_W'(p1_y);
      seg2  <= seg1;
      th2   <= th1;
      ax2   <= ax_r;
      ay2   <= ay_r;
      seg3  <= seg2;
      th3   <= th2;
      ax3   <= a_hi;
      ay3   <= b_hi;
      seg4  <= seg3;
      th4   <= th3;
      ax4   <= a_lo;
      ay4   <= b_lo;
      seg5  <= seg4;
      sqx5  <= ax4 * ax4;
      sqy5  <= ay4 * ay4;
      numx5 <= ay4 * th4;
      numy5 <= ax4 * th4;
      sum_sq         <= {1'b0, sqx5} + {1'b0, sqy5};
      sum_side.seg   <= seg5;
      sum_side.num_x <= numx5;
      sum_side.num_y <= numy5;
    end
  end

endmodule

// ===== rtl/sqe_root.sv =====
// ----------------------------------------------------------------------------
// sqe_root
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module sqe_root (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          adv,
  input  logic                          in_valid,
  input  logic [sqe_pkg::SQ_W-1:0]      in_sq,
  input  sqe_pkg::side_t                in_side,
  output logic                          out_valid,
  output logic [sqe_pkg::ROOT_W-1:0]    out_root,
  output sqe_pkg::side_t                out_side
);
  import sqe_pkg::*;

  logic              v    [1:ROOT_W];
  logic [63:0]       rem  [1:ROOT_W-1];
  logic [ROOT_W-1:0] root [1:ROOT_W];
  side_t             side [1:ROOT_W];

  for (genvar i = 0; i < ROOT_W; i++) begin : g_stage
    localparam int B = ROOT_W - 1 - i;
    logic              v_in;
    logic [63:0]       r_in;
    logic [ROOT_W-1:0] q_in;
    side_t             s_in;
    logic [63:0]       trial;
    logic              fits;

    if (i == 0) begin : g_first
      assign v_in = in_valid;
      assign r_in = 64'(in_sq);
      assign q_in = '0;
      assign s_in = in_side;
    end else begin : g_next
      assign v_in = v[i];
      assign r_in = rem[i];
      assign q_in = root[i];
      assign s_in = side[i];
    end

    assign trial = (64'(q_in) << (B + 1)) + (64'd1 << (2 * B));
    assign fits  = r_in >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        v[i+1] <= 1'b0;
      end else if (adv) begin
        v[i+1] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        side[i+1] <= s_in;
        root[i+1] <= fits ? (q_in | (ROOT_W'(1) << B)) : q_in;
      end
    end

    if (i < ROOT_W - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (adv) begin
          rem[i+1] <= fits ? (r_in - trial) : r_in;
        end
      end
    end
  end

  assign out_valid = v[ROOT_W];
  assign out_root  = root[ROOT_W];
  assign out_side  = side[ROOT_W];

endmodule

// ===== rtl/sqe_div.sv =====
// ----------------------------------------------------------------------------
// sqe_div
// Two-lane pipelined restoring divider for the rounded normal magnitudes.
// ----------------------------------------------------------------------------
module sqe_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          adv,
  input  logic                          in_valid,
  input  logic [sqe_pkg::ROOT_W-1:0]    in_root,
  input  sqe_pkg::side_t                in_side,
  output logic                          out_valid,
  output sqe_pkg::seg_t                 out_seg,
  output logic [sqe_pkg::MAG_W-1:0]     mag_x,
  output logic [sqe_pkg::MAG_W-1:0]     mag_y
);
  import sqe_pkg::*;

  logic             v0;
  seg_t             seg0;
  logic [DEN_W-1:0] den0;
  logic [NUM_W-1:0] nx0, ny0;

  logic             v    [1:MAG_W];
  seg_t             seg  [1:MAG_W];
  logic [NUM_W-1:0] remx [1:MAG_W-1];
  logic [NUM_W-1:0] remy [1:MAG_W-1];
  logic [MAG_W-1:0] qx   [1:MAG_W];
  logic [MAG_W-1:0] qy   [1:MAG_W];
  logic [DEN_W-1:0] den  [1:MAG_W-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (adv) begin
      v0 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      seg0 <= in_side.seg;
      den0 <= {in_root, 1'b0};
      nx0  <= NUM_W'(in_side.num_x) + NUM_W'(in_root);
      ny0  <= NUM_W'(in_side.num_y) + NUM_W'(in_root);
    end
  end

  for (genvar i = 0; i < MAG_W; i++) begin : g_stage
    localparam int B = MAG_W - 1 - i;
    logic             v_in;
    seg_t             s_in;
    logic [NUM_W-1:0] rx_in, ry_in;
    logic [MAG_W-1:0] qx_in, qy_in;
    logic [DEN_W-1:0] d_in;
    logic [63:0]      d_sh;
    logic             fx, fy;

    if (i == 0) begin : g_first
      assign v_in  = v0;
      assign s_in  = seg0;
      assign rx_in = nx0;
      assign ry_in = ny0;
      assign qx_in = '0;
      assign qy_in = '0;
      assign d_in  = den0;
    end else begin : g_next
      assign v_in  = v[i];
      assign s_in  = seg[i];
      assign rx_in = remx[i];
      assign ry_in = remy[i];
      assign qx_in = qx[i];
      assign qy_in = qy[i];
      assign d_in  = den[i];
    end

    assign d_sh = 64'(d_in) << B;
    assign fx   = 64'(rx_in) >= d_sh;
    assign fy   = 64'(ry_in) >= d_sh;

    always_ff @(posedge clk) begin
      if (rst) begin
        v[i+1] <= 1'b0;
      end else if (adv) begin
        v[i+1] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        seg[i+1] <= s_in;
        qx[i+1]  <= fx ? (qx_in | (MAG_W'(1) << B)) : qx_in;
        qy[i+1]  <= fy ? (qy_in | (MAG_W'(1) << B)) : qy_in;
      end
    end

    if (i < MAG_W - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (adv) begin
          remx[i+1] <= fx ? NUM_W'(64'(rx_in) - d_sh) : rx_in;
          remy[i+1] <= fy ? NUM_W'(64'(ry_in) - d_sh) : ry_in;
          den[i+1]  <= d_in;
        end
      end
    end
  end

  assign out_valid = v[MAG_W];
  assign out_seg   = seg[MAG_W];
  assign mag_x     = qx[MAG_W];
  assign mag_y     = qy[MAG_W];

endmodule

// ===== rtl/sqe_emit.sv =====
// ----------------------------------------------------------------------------
// sqe_emit
// Applies the normal signs and serializes six vertices through an output
// register.
// ----------------------------------------------------------------------------
module sqe_emit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                tail_valid,
  input  sqe_pkg::seg_t                       tail_seg,
  input  logic [sqe_pkg::MAG_W-1:0]           mag_x,
  input  logic [sqe_pkg::MAG_W-1:0]           mag_y,
  output logic                                adv,
  input  logic                                out_stall,
  output logic                                out_valid,
  output logic signed [sqe_pkg::COORD_W-1:0]  vert_x,
  output logic signed [sqe_pkg::COORD_W-1:0]  vert_y,
  output logic signed [sqe_pkg::COORD_W-1:0]  vert_z,
  output logic [sqe_pkg::COLOR_W-1:0]         out_red,
  output logic [sqe_pkg::COLOR_W-1:0]         out_green,
  output logic [sqe_pkg::COLOR_W-1:0]         out_blue,
  output logic [sqe_pkg::IDX_W-1:0]           vertex_index,
  output logic                                last_vertex
);
  import sqe_pkg::*;

  logic                    busy;
  logic [IDX_W-1:0]        k;
  seg_t                    it;
  logic signed [N_W-1:0]   nx, ny;
  logic signed [N_W-1:0]   nx_next, ny_next;
  logic                    load_out, finish, take;
  logic                    use_p2, neg;
  logic signed [COORD_W-1:0] px, py;
  logic signed [33:0]      sx, sy;

  assign load_out = busy && (!out_valid || !out_stall);
  assign finish   = load_out && (k == VTX_LAST);
  assign take     = tail_valid && (!busy || finish);
  assign adv      = !tail_valid || take;

  always_comb begin
    nx_next = '0;
    ny_next = '0;
    if (tail_seg.nonzero) begin
      nx_next = tail_seg.dy_pos ? -$signed({2'b00, mag_x}) : $signed({2'b00, mag_x});
      ny_next = tail_seg.dx_neg ? -$signed({2'b00, mag_y}) : $signed({2'b00, mag_y});
    end
  end

  always_comb begin
    use_p2 = vtx_use_p2(k);
    neg    = vtx_neg(k);
    px     = use_p2 ? it.p2_x : it.p1_x;
    py     = use_p2 ? it.p2_y : it.p1_y;
    sx     = neg ? (34'(px) - 34'(nx)) : (34'(px) + 34'(nx));
    sy     = neg ? (34'(py) - 34'(ny)) : (34'(py) + 34'(ny));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      k         <= VTX_FIRST;
      out_valid <= 1'b0;
    end else begin
      if (take) begin
        busy <= 1'b1;
        k    <= VTX_FIRST;
      end else if (finish) begin
        busy <= 1'b0;
      end else if (load_out) begin
        k <= k + 3'd1;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      it <= tail_seg;
      nx <= nx_next;
      ny <= ny_next;
    end
    if (load_out) begin
      vert_x       <= sat32(sx);
      vert_y       <= sat32(sy);
      vert_z       <= use_p2 ? it.p2_z : it.p1_z;
      out_red      <= it.red;
      out_green    <= it.green;
      out_blue     <= it.blue;
      vertex_index <= k;
      last_vertex  <= (k == VTX_LAST);
    end
  end

endmodule
